// ===== sv/pts_pkg.sv =====
// Shared types, widths and codes for the partial track statistics unit.
// No dependencies; imported by every module of the block.
package pts_pkg;

    localparam int TRACK_W    = 10;
    localparam int OP_W       = 2;
    localparam int FREQ_W     = 24;
    localparam int AMP_W      = 16;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int PTS_TRACKS  = 1024;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_FLOOR = 2'd2;

    localparam logic [FREQ_W-1:0] FREQ_ONES = {FREQ_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

    typedef struct packed {
        logic [FREQ_W-1:0] min_freq;
        logic [FREQ_W-1:0] max_freq;
        logic [SUM_W-1:0]  freq_sum;
        logic [AMP_W-1:0]  peak_amp;
        logic [CNT_W-1:0]  nodes;
    } entry_t;

    // one queued transaction, already classified by the front end
    typedef struct packed {
        logic [OP_W-1:0]    kind;
        logic               hit;
        logic [TRACK_W-1:0] track;
        logic [FREQ_W-1:0]  freq;
        logic [AMP_W-1:0]   amp;
    } item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] low_freq_limit;
        logic [FREQ_W-1:0] high_freq_limit;
        logic [AMP_W-1:0]  amp_floor;
    } cfg_t;

    typedef struct packed {
        logic [TRACK_W-1:0] track_out;
        logic [FREQ_W-1:0]  lowest_freq;
        logic [FREQ_W-1:0]  highest_freq;
        logic [FREQ_W-1:0]  mean_freq;
        logic [AMP_W-1:0]   peak_amp;
        logic [CNT_W-1:0]   node_count;
        logic               excluded;
        logic               saturated;
    } result_t;

    function automatic entry_t reset_entry();
        entry_t e;
        e.min_freq = FREQ_ONES;
        e.max_freq = '0;
        e.freq_sum = '0;
        e.peak_amp = '0;
        e.nodes    = '0;
        return e;
    endfunction

endpackage

// ===== sv/pts_front.sv =====
// Front end: accepts input transactions, drops the ones with no effect and
// classifies the rest for the queue. Depends on pts_pkg.
module pts_front
    import pts_pkg::*;
#(
    parameter int TRACKS = PTS_TRACKS
)
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [TRACK_W-1:0] track,
    input  logic [FREQ_W-1:0]  node_freq,
    input  logic [AMP_W-1:0]   node_amp,
    input  logic               q_full,
    input  logic               init_busy,
    output logic               q_push,
    output item_t              q_data
);

    logic hit;
    logic keep;

    assign hit      = {7'd0, track} < 17'(TRACKS);
    assign in_stall = q_full | init_busy;

    always_comb
    begin
        unique case (operation) inside
            OP_ADD, OP_CLEAR: keep = hit;
            OP_QUERY:         keep = 1'b1;   // out-of-range query still answers
            default:          keep = 1'b0;
        endcase
    end

    assign q_push       = in_valid & ~in_stall & keep;
    assign q_data.kind  = operation;
    assign q_data.hit   = hit;
    assign q_data.track = track;
    assign q_data.freq  = node_freq;
    assign q_data.amp   = node_amp;

endmodule

// ===== sv/pts_queue.sv =====
// Short queue between front end and back end.
// Depends on pts_pkg.
module pts_queue
    import pts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/pts_div.sv =====
// Restoring divider, one quotient bit per cycle, for the mean frequency.
// Depends on pts_pkg.
module pts_div
    import pts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/pts_back.sv =====
// Back end: track statistics memory, read-modify-write sequencer, mean
// division and the output register. Depends on pts_pkg and pts_div.
module pts_back
    import pts_pkg::*;
#(
    parameter int TRACKS = PTS_TRACKS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   q_head,
    input  logic    q_empty,
    output logic    q_pop,
    output logic    init_busy,
    input  cfg_t    cfg,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t result
);

    localparam int AW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    entry_t         mem [TRACKS];
    entry_t         rdata_reg;

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  init_reg, init_next;
    item_t          cur_reg;
    result_t        pend_reg;
    result_t        res_reg;
    logic           out_valid_reg, out_valid_next;

    logic [31:0]    head_ext, cur_ext;
    logic [AW-1:0]  rd_addr, cur_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    entry_t         mem_wdata;
    entry_t         added;
    logic [SUM_W:0] sum_wide;
    result_t        stats;
    logic           div_start, div_done;
    logic [SUM_W-1:0] div_quo;
    logic           out_load;

    assign head_ext = 32'(q_head.track);
    assign cur_ext  = 32'(cur_reg.track);
    assign rd_addr  = q_head.hit ? head_ext[AW-1:0] : '0;
    assign cur_addr = cur_ext[AW-1:0];

    // add update; min and max compare independently
    always_comb
    begin
        added          = rdata_reg;
        sum_wide       = {1'b0, rdata_reg.freq_sum} + (SUM_W+1)'(cur_reg.freq);
        if (cur_reg.freq > rdata_reg.max_freq)
        begin
            added.max_freq = cur_reg.freq;
        end
        if (cur_reg.freq < rdata_reg.min_freq)
        begin
            added.min_freq = cur_reg.freq;
        end
        if (cur_reg.amp > rdata_reg.peak_amp)
        begin
            added.peak_amp = cur_reg.amp;
        end
        if (rdata_reg.nodes != CNT_MAX)
        begin
            added.freq_sum = sum_wide[SUM_W-1:0];
            added.nodes    = rdata_reg.nodes + 1'b1;
        end
    end

    // query statistics; out-of-range tracks read as empty
    always_comb
    begin
        stats = '0;
        stats.track_out = cur_reg.track;
        if (cur_reg.hit)
        begin
            stats.highest_freq = rdata_reg.max_freq;
            stats.lowest_freq  = (rdata_reg.min_freq == FREQ_ONES) ? rdata_reg.max_freq
                                                                  : rdata_reg.min_freq;
            stats.peak_amp     = rdata_reg.peak_amp;
            stats.node_count   = rdata_reg.nodes;
        end
        stats.saturated = stats.node_count == CNT_MAX;
        stats.excluded  = (stats.peak_amp < cfg.amp_floor)
                        | (stats.lowest_freq < cfg.low_freq_limit)
                        | (stats.highest_freq > cfg.high_freq_limit);
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = cur_addr;
        mem_wdata  = reset_entry();
        div_start  = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_reg;
                init_next = init_reg + 1'b1;
                if (init_reg == AW'(TRACKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cur_reg.kind) inside
                    OP_ADD:
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = added;
                        state_next = S_IDLE;
                    end
                    OP_QUERY:
                    begin
                        if (stats.node_count != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    default:
                    begin
                        mem_we     = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (state_reg == S_EXEC)
        begin
            pend_reg <= stats;   // mean_freq is zero here
        end
        else if (state_reg == S_DIV && div_done)
        begin
            pend_reg.mean_freq <= div_quo[FREQ_W-1:0];
        end
        if (out_load)
        begin
            res_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    pts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rdata_reg.freq_sum),
        .divisor  (rdata_reg.nodes),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign init_busy = state_reg == S_INIT;
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

// ===== sv/partial_track_statistics_unit.sv =====
// Top level of the partial track statistics unit: config registers, front end,
// queue and back end. Depends on pts_pkg, pts_front, pts_queue, pts_back.
//
//  channel   handshake                 payload
//  input     in_valid / in_stall       operation, track, node_freq, node_amp
//  output    out_valid / out_stall     track_out .. saturated
//  config    cfg_we                    cfg_index, cfg_data
//
// Add and clear in the back end are a memory read, then a write.
// A query waits on the 40-step mean divider when the track holds any nodes.
// After reset a clearing pass writes every track while in_stall is high.
// A four-entry queue lets the front end accept while the back end works;
// a pending result in the output register does not block adds or clears.
module partial_track_statistics_unit
    import pts_pkg::*;
#(
    parameter int TRACKS = PTS_TRACKS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [TRACK_W-1:0]    track,
    input  logic [FREQ_W-1:0]     node_freq,
    input  logic [AMP_W-1:0]      node_amp,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TRACK_W-1:0]    track_out,
    output logic [FREQ_W-1:0]     lowest_freq,
    output logic [FREQ_W-1:0]     highest_freq,
    output logic [FREQ_W-1:0]     mean_freq,
    output logic [AMP_W-1:0]      peak_amp,
    output logic [CNT_W-1:0]      node_count,
    output logic                  excluded,
    output logic                  saturated,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    item_t   q_in, q_head;
    logic    q_push, q_pop, q_full, q_empty;
    logic    init_busy;
    result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_FREQ:  cfg_next.low_freq_limit  = cfg_data;
                CFG_HIGH_FREQ: cfg_next.high_freq_limit = cfg_data;
                CFG_AMP_FLOOR: cfg_next.amp_floor       = cfg_data[AMP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_freq_limit  <= '0;
            cfg_reg.high_freq_limit <= FREQ_ONES;
            cfg_reg.amp_floor       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pts_front #(.TRACKS(TRACKS)) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .track     (track),
        .node_freq (node_freq),
        .node_amp  (node_amp),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    pts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pts_back #(.TRACKS(TRACKS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign track_out    = result.track_out;
    assign lowest_freq  = result.lowest_freq;
    assign highest_freq = result.highest_freq;
    assign mean_freq    = result.mean_freq;
    assign peak_amp     = result.peak_amp;
    assign node_count   = result.node_count;
    assign excluded     = result.excluded;
    assign saturated    = result.saturated;

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> (!q_pop && !q_push && !out_valid))
        else $error("activity during clearing pass");

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        !init_busy |=> !init_busy)
        else $error("clearing pass restarted");

endmodule

// ===== tb/pts_track_monitor.sv =====
`timescale 1ns / 100ps
// Track statistics monitor: mirrors the per-track store and the threshold registers,
// predicts each query result and compares it with the output channel. Depends on pts_pkg.
module pts_track_monitor
    import pts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [TRACK_W-1:0]    track,
    input  logic [FREQ_W-1:0]     node_freq,
    input  logic [AMP_W-1:0]      node_amp,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [TRACK_W-1:0]    track_out,
    input  logic [FREQ_W-1:0]     lowest_freq,
    input  logic [FREQ_W-1:0]     highest_freq,
    input  logic [FREQ_W-1:0]     mean_freq,
    input  logic [AMP_W-1:0]      peak_amp,
    input  logic [CNT_W-1:0]      node_count,
    input  logic                  excluded,
    input  logic                  saturated,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  run_done,
    output int                    fail_count,
    output int                    outstanding,
    output int                    results_checked
);

    localparam int MAX_REPORTS = 10;

    entry_t  track_stats [PTS_TRACKS];
    cfg_t    limits;
    result_t query_results_due [$];
    int      mismatches;
    int      checked;
    bit      leftover_counted;

    function automatic entry_t empty_entry();
        entry_t e;
        e.min_freq = FREQ_ONES;
        e.max_freq = '0;
        e.freq_sum = '0;
        e.peak_amp = '0;
        e.nodes    = '0;
        return e;
    endfunction

    task automatic apply_track_op(input logic [OP_W-1:0] op, input logic [TRACK_W-1:0] trk,
                                  input logic [FREQ_W-1:0] f, input logic [AMP_W-1:0] a);
        entry_t           e;
        result_t          r;
        logic [SUM_W-1:0] quo;
        e = track_stats[trk];
        case (op)
            OP_ADD:
            begin
                // min and max are tracked independently
                if (f > e.max_freq)
                    e.max_freq = f;
                if (f < e.min_freq)
                    e.min_freq = f;
                if (a > e.peak_amp)
                    e.peak_amp = a;
                // sum and count freeze once the count saturates
                if (e.nodes != CNT_MAX)
                begin
                    e.freq_sum = e.freq_sum + f;
                    e.nodes    = e.nodes + 1'b1;
                end
                track_stats[trk] = e;
            end
            OP_CLEAR:
                track_stats[trk] = empty_entry();
            OP_QUERY:
            begin
                r.track_out    = trk;
                r.highest_freq = e.max_freq;
                // a minimum never lowered reads back as the maximum
                r.lowest_freq  = (e.min_freq == FREQ_ONES) ? e.max_freq : e.min_freq;
                r.peak_amp     = e.peak_amp;
                r.node_count   = e.nodes;
                quo            = (e.nodes != 0) ? e.freq_sum / e.nodes : '0;
                r.mean_freq    = quo[FREQ_W-1:0];
                r.excluded     = (r.peak_amp < limits.amp_floor) ||
                                 (r.lowest_freq < limits.low_freq_limit) ||
                                 (r.highest_freq > limits.high_freq_limit);
                r.saturated    = (e.nodes == CNT_MAX);
                query_results_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got = {track_out, lowest_freq, highest_freq, mean_freq, peak_amp, node_count,
               excluded, saturated};
        if (query_results_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result for track %0d with no query outstanding",
                         $time, track_out);
        end
        else
        begin
            want = query_results_due.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch exp trk=%0d lo=%h hi=%h mean=%h pk=%h n=%0d ex=%b sat=%b",
                             $time, want.track_out, want.lowest_freq, want.highest_freq,
                             want.mean_freq, want.peak_amp, want.node_count, want.excluded,
                             want.saturated);
                    $display("%0t:          got trk=%0d lo=%h hi=%h mean=%h pk=%h n=%0d ex=%b sat=%b",
                             $time, got.track_out, got.lowest_freq, got.highest_freq,
                             got.mean_freq, got.peak_amp, got.node_count, got.excluded,
                             got.saturated);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < PTS_TRACKS; t++)
                track_stats[t] = empty_entry();
            limits.low_freq_limit  = '0;
            limits.high_freq_limit = FREQ_ONES;
            limits.amp_floor       = '0;
            query_results_due.delete();
            mismatches       = 0;
            checked          = 0;
            leftover_counted = 1'b0;
            fail_count      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOW_FREQ:  limits.low_freq_limit  = cfg_data;
                    CFG_HIGH_FREQ: limits.high_freq_limit = cfg_data;
                    CFG_AMP_FLOOR: limits.amp_floor       = cfg_data[AMP_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                apply_track_op(operation, track, node_freq, node_amp);
            if (run_done && !leftover_counted)
            begin
                leftover_counted = 1'b1;
                if (query_results_due.size() != 0)
                begin
                    $display("%0t: %0d query results never arrived",
                             $time, query_results_due.size());
                    mismatches += query_results_due.size();
                end
            end
            fail_count      <= mismatches;
            outstanding     <= query_results_due.size();
            results_checked <= checked;
        end
    end

endmodule

// ===== tb/partial_track_statistics_unit_tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for partial_track_statistics_unit: directed cases and random
// phases under several thresholds. Depends on pts_pkg, pts_track_monitor.
module partial_track_statistics_unit_tb
    import pts_pkg::*;
;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned FREQ_MAX      = 24'hFFFFFF;
    localparam int unsigned AMP_MAX       = 16'hFFFF;
    localparam int unsigned LIMIT         = 1500000;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          POOL_SIZE     = 16;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [OP_W-1:0]       operation = OP_ADD;
    logic [TRACK_W-1:0]    track     = '0;
    logic [FREQ_W-1:0]     node_freq = '0;
    logic [AMP_W-1:0]      node_amp  = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOW_FREQ;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  run_done  = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    logic [TRACK_W-1:0]    track_out;
    logic [FREQ_W-1:0]     lowest_freq;
    logic [FREQ_W-1:0]     highest_freq;
    logic [FREQ_W-1:0]     mean_freq;
    logic [AMP_W-1:0]      peak_amp;
    logic [CNT_W-1:0]      node_count;
    logic                  excluded;
    logic                  saturated;

    int fail_count;
    int outstanding;
    int results_checked;

    stall_mode_t stall_mode  = STALL_NONE;
    int          hold_ask    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int unsigned stall_tick  = 0;
    int unsigned cycle_count = 0;

    int unsigned cur_lo    = 0;
    int unsigned cur_hi    = FREQ_MAX;
    int unsigned cur_floor = 0;
    int unsigned pool [POOL_SIZE];
    int n_add, n_query, n_clear, n_unused, n_settings;

    partial_track_statistics_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .track        (track),
        .node_freq    (node_freq),
        .node_amp     (node_amp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .track_out    (track_out),
        .lowest_freq  (lowest_freq),
        .highest_freq (highest_freq),
        .mean_freq    (mean_freq),
        .peak_amp     (peak_amp),
        .node_count   (node_count),
        .excluded     (excluded),
        .saturated    (saturated),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pts_track_monitor mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .track           (track),
        .node_freq       (node_freq),
        .node_amp        (node_amp),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .track_out       (track_out),
        .lowest_freq     (lowest_freq),
        .highest_freq    (highest_freq),
        .mean_freq       (mean_freq),
        .peak_amp        (peak_amp),
        .node_count      (node_count),
        .excluded        (excluded),
        .saturated       (saturated),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .run_done        (run_done),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver back-pressure; a hold request overrides the current pattern
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
                STALL_PATTERN: out_stall <= ((stall_tick % 11) < 4);
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input int unsigned trk,
                             input int unsigned f, input int unsigned a);
        in_valid  <= 1'b1;
        operation <= op;
        track     <= TRACK_W'(trk);
        node_freq <= FREQ_W'(f);
        node_amp  <= AMP_W'(a);
        do
            @(posedge clk);
        while (in_stall);
        if (op == OP_ADD)
            n_add++;
        else if (op == OP_QUERY)
            n_query++;
        else if (op == OP_CLEAR)
            n_clear++;
        else
            n_unused++;
    endtask

    // adds and clears give no result, so let the back end finish after the last one
    task automatic wait_drain();
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_limits(input int unsigned lo, input int unsigned hi,
                                  input int unsigned fl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW_FREQ;
        cfg_data  <= CFG_DATA_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_HIGH_FREQ;
        cfg_data  <= CFG_DATA_W'(hi);
        @(posedge clk);
        // junk in the upper byte must be masked off
        cfg_index <= CFG_AMP_FLOOR;
        cfg_data  <= {8'($urandom_range(0, 255)), 16'(fl)};
        @(posedge clk);
        // unmapped index, must be ignored
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom_range(0, FREQ_MAX));
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_lo     = lo;
        cur_hi     = hi;
        cur_floor  = fl & AMP_MAX;
        n_settings++;
    endtask

    // frequencies cluster on the extremes and around the current limits
    function automatic int unsigned pick_freq();
        int unsigned base;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return FREQ_MAX;
            2: base = cur_lo;
            3: base = cur_hi;
            default: return $urandom_range(0, FREQ_MAX);
        endcase
        if (base < 4)
            base = 4;
        if (base > FREQ_MAX - 4)
            base = FREQ_MAX - 4;
        return base - 4 + $urandom_range(0, 8);
    endfunction

    function automatic int unsigned pick_amp();
        int unsigned base;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return AMP_MAX;
            2: base = cur_floor;
            default: return $urandom_range(0, AMP_MAX);
        endcase
        if (base < 2)
            base = 2;
        if (base > AMP_MAX - 2)
            base = AMP_MAX - 2;
        return base - 2 + $urandom_range(0, 4);
    endfunction

    task automatic random_phase(input int n, input bit use_gaps);
        int              burst_left;
        int              r;
        int unsigned     trk;
        logic [OP_W-1:0] op;
        // a small pool of hot tracks so statistics build up between clears
        pool[0] = 0;
        pool[1] = PTS_TRACKS - 1;
        for (int k = 2; k < POOL_SIZE; k++)
            pool[k] = $urandom_range(0, PTS_TRACKS - 1);
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 62)
                op = OP_ADD;
            else if (r < 90)
                op = OP_QUERY;
            else if (r < 96)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 99) < 85)
                trk = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                trk = $urandom_range(0, PTS_TRACKS - 1);
            send_item(op, trk, pick_freq(), pick_amp());
            if (use_gaps)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                    burst_left = $urandom_range(1, 24);
                end
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        n_add      = 0;
        n_query    = 0;
        n_clear    = 0;
        n_unused   = 0;
        n_settings = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases under reset thresholds; the first waits out the clearing pass
        send_item(OP_QUERY, 0, 0, 0);
        send_item(OP_ADD, 0, FREQ_MAX, AMP_MAX);
        send_item(OP_QUERY, 0, 0, 0);                 // min never lowered
        send_item(OP_ADD, PTS_TRACKS - 1, 0, 0);
        send_item(OP_QUERY, PTS_TRACKS - 1, 0, 0);
        send_item(OP_ADD, PTS_TRACKS - 1, 24'h123456, 16'h8000);
        send_item(OP_QUERY, PTS_TRACKS - 1, 0, 0);
        send_item(OP_CLEAR, PTS_TRACKS - 1, FREQ_MAX, AMP_MAX);
        send_item(OP_QUERY, PTS_TRACKS - 1, FREQ_MAX, AMP_MAX);
        send_item(OP_UNUSED, 5, FREQ_MAX, AMP_MAX);   // no state change, no result
        send_item(OP_QUERY, 5, 0, 0);
        send_item(OP_ADD, 5, 24'h800000, 16'h1234);
        send_item(OP_ADD, 5, 24'h000100, 16'h0001);
        send_item(OP_QUERY, 5, 0, 0);
        // back-to-back read-modify-write on one track
        send_item(OP_ADD, 7, 24'h10, 16'h10);
        send_item(OP_ADD, 7, 24'h20, 16'h5);
        send_item(OP_ADD, 7, 24'h5, 16'h30);
        send_item(OP_QUERY, 7, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_QUERY, 0, 0, 0);
        in_valid <= 1'b0;
        wait_drain();

        // everything excluded
        program_limits(FREQ_MAX, 0, AMP_MAX);
        send_item(OP_QUERY, 5, 0, 0);
        send_item(OP_QUERY, 7, 0, 0);
        send_item(OP_QUERY, PTS_TRACKS - 1, 0, 0);
        stall_mode <= STALL_RANDOM;
        random_phase(150, 1'b1);
        wait_drain();

        // nothing excluded
        program_limits(0, FREQ_MAX, 0);
        stall_mode <= STALL_PATTERN;
        random_phase(350, 1'b1);
        wait_drain();

        // no idling on either side, then a long receiver hold while queries pile up
        program_limits($urandom_range(0, 24'h600000), $urandom_range(24'hA00000, FREQ_MAX),
                       $urandom_range(0, 16'h6000));
        stall_mode <= STALL_NONE;
        random_phase(300, 1'b0);
        hold_ask <= hold_ask + 1;
        for (int i = 0; i < 40; i++)
            send_item(($urandom_range(0, 99) < 70) ? OP_QUERY : OP_ADD,
                      $urandom_range(0, 3), pick_freq(), pick_amp());
        in_valid <= 1'b0;
        wait_drain();

        program_limits(24'h400000, 24'hC00000, 16'h4000);
        stall_mode <= STALL_RANDOM;
        random_phase(450, 1'b1);
        wait_drain();

        program_limits($urandom_range(0, FREQ_MAX), $urandom_range(0, FREQ_MAX),
                       $urandom_range(0, AMP_MAX));
        stall_mode <= STALL_PATTERN;
        random_phase(500, 1'b1);
        wait_drain();

        run_done <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Ran %0d adds, %0d queries, %0d clears, %0d unused ops over %0d limit settings.",
                 n_add, n_query, n_clear, n_unused, n_settings);
        $display("Compared %0d query results against the mirrored track store.",
                 results_checked);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
